>>> sv/cbeq_pkg.sv
// Shared types and constants for the cascaded biquad equalizer.
// No dependencies; used by cbeq_mul and cascaded_biquad_equalizer_top.
package cbeq_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int DELAY_W    = 48;
  localparam int DELAY_FRAC = 40;
  localparam int NCOEF      = 5;
  localparam int DIGIT_W    = 8;
  localparam int NDIGIT     = COEF_W / DIGIT_W;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int DCNT_W     = $clog2(NDIGIT + 1);

  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end_in;
    logic [3:0]                 band_num;
    logic [2:0]                 coef_select;
    logic signed [COEF_W-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
    logic                       clipped;
  } out_item_t;

endpackage

>>> sv/cbeq_mul.sv
// Digit-serial signed multiplier: coefficient times sample, one 8-bit digit per cycle.
// Depends on cbeq_pkg for widths.
module cbeq_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [cbeq_pkg::COEF_W-1:0]     coef,
  input  logic signed [cbeq_pkg::SAMPLE_W-1:0]   x,
  output logic                                   done,
  output logic signed [cbeq_pkg::PROD_W-1:0]     prod
);

  logic [cbeq_pkg::DCNT_W-1:0]                     cnt;
  logic                                            first;
  logic [cbeq_pkg::COEF_W-1:0]                     creg;
  logic signed [cbeq_pkg::SAMPLE_W-1:0]            xreg;
  logic [cbeq_pkg::DIGIT_W-1:0]                    top;
  logic signed [cbeq_pkg::DIGIT_W:0]               dig;
  logic signed [cbeq_pkg::DIGIT_W+cbeq_pkg::SAMPLE_W:0] pp;
  logic signed [cbeq_pkg::PROD_W-1:0]              prod_next;

  // Most significant digit first; only the top digit carries the sign.
  assign top       = creg[cbeq_pkg::COEF_W-1 -: cbeq_pkg::DIGIT_W];
  assign dig       = first ? {top[cbeq_pkg::DIGIT_W-1], top} : {1'b0, top};
  assign pp        = dig * xreg;
  assign prod_next = (prod <<< cbeq_pkg::DIGIT_W) + cbeq_pkg::PROD_W'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= cbeq_pkg::DCNT_W'(cbeq_pkg::NDIGIT);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == cbeq_pkg::DCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      creg  <= coef;
      xreg  <= x;
      prod  <= '0;
      first <= 1'b1;
    end else if (cnt != '0) begin
      prod  <= prod_next;
      creg  <= creg << cbeq_pkg::DIGIT_W;
      first <= 1'b0;
    end
  end

endmodule

>>> sv/cascaded_biquad_equalizer_top.sv
// Cascaded biquad equalizer, transposed direct form II, one shared digit-serial multiplier.
// Depends on cbeq_pkg (types, widths, codes) and cbeq_mul.
//
//   channel | signals                    | moves
//   --------+----------------------------+-----------------------------------------
//   request | req_valid, req_ready, req  | sample, coefficient load or delay clear
//   result  | rsp_valid, rsp_ready, rsp  | filtered sample, block end, clip flag
//
// Per sample, each of the five products per band runs fetch, start, multiplier wait, scale
// and combine, and the band output round follows the b0 product; the idle and result
// steps come before and after the band loop.
// Loads, clears and ignored commands are handled in the idle state. Reset is synchronous; the
// coefficient store reads as pass-through until an entry is written (valid bits).
// A finished sample waits in the result register; the sequencer holds until it is free.
module cascaded_biquad_equalizer_top #(
  parameter int BANDS          = 10,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cbeq_pkg::in_item_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cbeq_pkg::out_item_t  rsp
);

  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int NENTRY = BANDS * cbeq_pkg::NCOEF;
  localparam int ADDR_W = $clog2(NENTRY);
  localparam int ACC_W  = cbeq_pkg::PROD_W + 3;
  localparam int SHIFT  = COEF_FRAC_BITS + cbeq_pkg::SAMPLE_W - 1 - cbeq_pkg::DELAY_FRAC;
  localparam int RSHIFT = cbeq_pkg::DELAY_FRAC - (cbeq_pkg::SAMPLE_W - 1);

  localparam logic signed [cbeq_pkg::COEF_W-1:0] COEF_ONE =
    cbeq_pkg::COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] RND_T = ACC_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(64'd1 << (RSHIFT - 1));
  localparam logic signed [ACC_W-1:0] SMP_MAX =
    {{(ACC_W-cbeq_pkg::SAMPLE_W+1){1'b0}}, {(cbeq_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMP_MIN =
    {{(ACC_W-cbeq_pkg::SAMPLE_W+1){1'b1}}, {(cbeq_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] DLY_MAX =
    {{(ACC_W-cbeq_pkg::DELAY_W+1){1'b0}}, {(cbeq_pkg::DELAY_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DLY_MIN =
    {{(ACC_W-cbeq_pkg::DELAY_W+1){1'b1}}, {(cbeq_pkg::DELAY_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_START, S_WAIT, S_SCALE, S_COMBINE, S_ROUND, S_DONE
  } state_t;

  state_t                              state;
  logic [BAND_W-1:0]                   band;
  logic [2:0]                          sel;
  logic signed [cbeq_pkg::SAMPLE_W-1:0] x_cur;
  logic signed [cbeq_pkg::SAMPLE_W-1:0] y_cur;
  logic                                blk;
  logic                                clip;
  logic signed [ACC_W-1:0]             t_reg;
  logic signed [ACC_W-1:0]             acc_reg;
  logic signed [ACC_W-1:0]             n1;
  logic signed [ACC_W-1:0]             n2;
  logic signed [cbeq_pkg::DELAY_W-1:0] d1_mem [BANDS];
  logic signed [cbeq_pkg::DELAY_W-1:0] d2_mem [BANDS];

  logic [cbeq_pkg::COEF_W-1:0]         coef_mem [NENTRY];
  logic [NENTRY-1:0]                   coef_vld;
  logic [cbeq_pkg::COEF_W-1:0]         coef_rd;
  logic                                coef_rd_vld;
  logic [ADDR_W-1:0]                   rd_addr;
  logic [ADDR_W-1:0]                   wr_addr;
  logic                                wr_en;

  logic signed [cbeq_pkg::COEF_W-1:0]   coef_eff;
  logic signed [cbeq_pkg::SAMPLE_W-1:0] mul_x;
  logic                                 mul_start;
  logic                                 mul_done;
  logic signed [cbeq_pkg::PROD_W-1:0]   prod;

  logic signed [ACC_W-1:0]             t_next;
  logic signed [ACC_W-1:0]             d1_ext;
  logic signed [ACC_W-1:0]             d2_ext;
  logic signed [ACC_W-1:0]             n1_fin;
  logic signed [ACC_W-1:0]             n2_fin;
  logic signed [ACC_W-1:0]             y_rnd;

  function automatic logic signed [cbeq_pkg::DELAY_W-1:0] sat_dly(
    input logic signed [ACC_W-1:0] v
  );
    if (v > DLY_MAX) return DLY_MAX[cbeq_pkg::DELAY_W-1:0];
    if (v < DLY_MIN) return DLY_MIN[cbeq_pkg::DELAY_W-1:0];
    return v[cbeq_pkg::DELAY_W-1:0];
  endfunction

  function automatic logic signed [cbeq_pkg::SAMPLE_W-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    if (v > SMP_MAX) return SMP_MAX[cbeq_pkg::SAMPLE_W-1:0];
    if (v < SMP_MIN) return SMP_MIN[cbeq_pkg::SAMPLE_W-1:0];
    return v[cbeq_pkg::SAMPLE_W-1:0];
  endfunction

  assign req_ready = !rst && (state == S_IDLE);

  // Coefficient store: one write port from the request side, one registered read port.
  assign rd_addr = ADDR_W'(band) * ADDR_W'(cbeq_pkg::NCOEF) + ADDR_W'(sel);
  assign wr_addr = ADDR_W'(req.band_num) * ADDR_W'(cbeq_pkg::NCOEF)
                 + ADDR_W'(req.coef_select);
  assign wr_en   = req_valid && req_ready && (req.cmd == cbeq_pkg::CMD_LOAD)
                && (32'(req.band_num) < 32'(BANDS))
                && (32'(req.coef_select) < 32'(cbeq_pkg::NCOEF));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= req.coef_value;
    end
    coef_rd     <= coef_mem[rd_addr];
    coef_rd_vld <= coef_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (wr_en) begin
      coef_vld[wr_addr] <= 1'b1;
    end
  end

  // Unwritten entries read as pass-through: b0 one, the rest zero.
  assign coef_eff  = coef_rd_vld ? coef_rd : ((sel == cbeq_pkg::SEL_B0) ? COEF_ONE : '0);
  assign mul_x     = (sel == cbeq_pkg::SEL_A1 || sel == cbeq_pkg::SEL_A2) ? y_cur : x_cur;
  assign mul_start = (state == S_START);

  cbeq_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .coef  (coef_eff),
    .x     (mul_x),
    .done  (mul_done),
    .prod  (prod)
  );

  // Rescale product to delay format, round half up.
  assign t_next = (ACC_W'(prod) + RND_T) >>> SHIFT;
  assign d1_ext = ACC_W'(d1_mem[band]);
  assign d2_ext = ACC_W'(d2_mem[band]);
  assign n1_fin = n1 - t_reg;
  assign n2_fin = n2 - t_reg;
  assign y_rnd  = (acc_reg + RND_Y) >>> RSHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      band      <= '0;
      sel       <= cbeq_pkg::SEL_B0;
      clip      <= 1'b0;
      for (int i = 0; i < BANDS; i++) begin
        d1_mem[i] <= '0;
        d2_mem[i] <= '0;
      end
    end else begin
      // the result step refills the register itself
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            unique case (req.cmd)
              cbeq_pkg::CMD_PROCESS: begin
                x_cur <= req.sample_in;
                blk   <= req.block_end_in;
                clip  <= 1'b0;
                band  <= '0;
                sel   <= cbeq_pkg::SEL_B0;
                state <= S_FETCH;
              end
              cbeq_pkg::CMD_CLEAR: begin
                for (int i = 0; i < BANDS; i++) begin
                  d1_mem[i] <= '0;
                  d2_mem[i] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          t_reg <= t_next;
          state <= S_COMBINE;
        end
        S_COMBINE: begin
          case (sel)
            cbeq_pkg::SEL_B0: begin
              acc_reg <= t_reg + d1_ext;
              state   <= S_ROUND;
            end
            cbeq_pkg::SEL_B1: begin
              n1    <= t_reg + d2_ext;
              sel   <= cbeq_pkg::SEL_B2;
              state <= S_FETCH;
            end
            cbeq_pkg::SEL_B2: begin
              n2    <= t_reg;
              sel   <= cbeq_pkg::SEL_A1;
              state <= S_FETCH;
            end
            cbeq_pkg::SEL_A1: begin
              d1_mem[band] <= sat_dly(n1_fin);
              if (n1_fin > DLY_MAX || n1_fin < DLY_MIN) begin
                clip <= 1'b1;
              end
              sel   <= cbeq_pkg::SEL_A2;
              state <= S_FETCH;
            end
            cbeq_pkg::SEL_A2: begin
              d2_mem[band] <= sat_dly(n2_fin);
              if (n2_fin > DLY_MAX || n2_fin < DLY_MIN) begin
                clip <= 1'b1;
              end
              sel <= cbeq_pkg::SEL_B0;
              // advance to the next band with this band's output as its input
              if (band == BAND_W'(BANDS - 1)) begin
                state <= S_DONE;
              end else begin
                band  <= band + 1'b1;
                x_cur <= y_cur;
                state <= S_FETCH;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_ROUND: begin
          y_cur <= sat_smp(y_rnd);
          if (y_rnd > SMP_MAX || y_rnd < SMP_MIN) begin
            clip <= 1'b1;
          end
          sel   <= cbeq_pkg::SEL_B1;
          state <= S_FETCH;
        end
        S_DONE: begin
          // hold until the result register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.sample_out    <= y_cur;
            rsp.block_end_out <= blk;
            rsp.clipped       <= clip;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
